[sv/int64_alu_with_power_top_macros.svh]
// assertion macros for the 64-bit alu with power
// used by the top level only, no other dependencies
`ifndef INT64_ALU_WITH_POWER_TOP_MACROS_SVH
`define INT64_ALU_WITH_POWER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define I64ALU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define I64ALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/i64alu_pkg.sv]
// shared types and constants for the 64-bit alu with power
// no dependencies; imported by the interfaces' users and all modules
package i64alu_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned HALF_W = WORD_W / 2;

   typedef logic [WORD_W-1:0] word_type;

   // operation codes
   localparam logic [4:0] FN_EQ  = 5'd0;
   localparam logic [4:0] FN_NE  = 5'd1;
   localparam logic [4:0] FN_LE  = 5'd2;
   localparam logic [4:0] FN_GE  = 5'd3;
   localparam logic [4:0] FN_LT  = 5'd4;
   localparam logic [4:0] FN_GT  = 5'd5;
   localparam logic [4:0] FN_ADD = 5'd6;
   localparam logic [4:0] FN_SUB = 5'd7;
   localparam logic [4:0] FN_AND = 5'd8;
   localparam logic [4:0] FN_OR  = 5'd9;
   localparam logic [4:0] FN_XOR = 5'd10;
   localparam logic [4:0] FN_MUL = 5'd11;
   localparam logic [4:0] FN_DIV = 5'd12;
   localparam logic [4:0] FN_MOD = 5'd13;
   localparam logic [4:0] FN_ASR = 5'd14;
   localparam logic [4:0] FN_LSR = 5'd15;
   localparam logic [4:0] FN_SHL = 5'd16;
   localparam logic [4:0] FN_POW = 5'd17;

   // status codes
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO    = 2'd1;
   localparam logic [1:0] ST_SHIFT_RANGE = 2'd2;

   // multiplier partial product steps
   localparam logic [1:0] MUL_STEP_LL   = 2'd0;
   localparam logic [1:0] MUL_STEP_LH   = 2'd1;
   localparam logic [1:0] MUL_STEP_HL   = 2'd2;
   localparam logic [1:0] MUL_STEP_LAST = 2'd3;

   localparam logic [5:0] DIV_LAST_BIT = 6'd63;

   typedef struct packed {
      logic     start;
      word_type op_a;
      word_type op_b;
   } mul_req_type;

   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

endpackage

[sv/i64alu_req_if.sv]
// request channel: opcode and two signed 64-bit operands
// stand-alone, no package needed
interface i64alu_req_if;
   logic               valid;
   logic               ready;
   logic [4:0]         func;
   logic signed [63:0] left_operand;
   logic signed [63:0] right_operand;

   modport source (output valid, output func, output left_operand, output right_operand,
                   input ready);
   modport sink (input valid, input func, input left_operand, input right_operand,
                 output ready);
endinterface

[sv/i64alu_rsp_if.sv]
// response channel: signed 64-bit result and status code
// stand-alone, no package needed
interface i64alu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] result_value;
   logic [1:0]         status;

   modport source (output valid, output result_value, output status, input ready);
   modport sink (input valid, input result_value, input status, output ready);
endinterface

[sv/i64alu_mul.sv]
// iterative 64x64 multiplier, low 64 bits of the product, one 32x32 multiplier
// depends on i64alu_pkg
module i64alu_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  i64alu_pkg::mul_req_type mul_req,
   output logic                   done,
   output i64alu_pkg::word_type   product
);
   import i64alu_pkg::*;

   logic [1:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   word_type          a_ff, a_in, b_ff, b_in;
   word_type          prod_ff, prod_in;
   word_type          acc_ff, acc_in;
   logic [HALF_W-1:0] mul_x, mul_y;
   word_type          mul_p;

   always_comb begin
      case (step_ff)
         MUL_STEP_LH: begin
            mul_x = a_ff[HALF_W-1:0];
            mul_y = b_ff[WORD_W-1:HALF_W];
         end
         MUL_STEP_HL: begin
            mul_x = a_ff[WORD_W-1:HALF_W];
            mul_y = b_ff[HALF_W-1:0];
         end
         default: begin
            mul_x = a_ff[HALF_W-1:0];
            mul_y = b_ff[HALF_W-1:0];
         end
      endcase
   end

   assign mul_p = word_type'(mul_x) * word_type'(mul_y);

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (busy_ff) begin
         prod_in = mul_p;
         step_in = step_ff + 2'd1;
         if (step_ff == MUL_STEP_LH) begin
            acc_in = prod_ff;
         end else if (step_ff != MUL_STEP_LL) begin
            // cross terms only reach the upper half
            acc_in = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
         end
         if (step_ff == MUL_STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (mul_req.start) begin
         a_in    = mul_req.op_a;
         b_in    = mul_req.op_b;
         step_in = MUL_STEP_LL;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= MUL_STEP_LL;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[sv/i64alu_div.sv]
// restoring unsigned 64-bit divider, one quotient bit per cycle
// depends on i64alu_pkg
module i64alu_div (
   input  logic                   clock,
   input  logic                   reset,
   input  i64alu_pkg::div_req_type div_req,
   output logic                   done,
   output i64alu_pkg::word_type   quotient,
   output i64alu_pkg::word_type   remainder
);
   import i64alu_pkg::*;

   logic [5:0]    count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   word_type      rem_ff, rem_in;
   word_type      quo_ff, quo_in;
   word_type      den_ff, den_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W+1:0] trial;
   logic              borrow;

   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign borrow  = trial[WORD_W+1];

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (busy_ff) begin
         rem_in   = borrow ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];
         quo_in   = {quo_ff[WORD_W-2:0], ~borrow};
         count_in = count_ff + 6'd1;
         if (count_ff == DIV_LAST_BIT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (div_req.start) begin
         rem_in   = '0;
         quo_in   = div_req.dividend;
         den_in   = div_req.divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[sv/int64_alu_with_power_top.sv]
// 64-bit integer alu with power: top level sequencer and output register
// depends on i64alu_pkg, i64alu_req_if, i64alu_rsp_if, i64alu_mul, i64alu_div
//
// Usage: an item on req (func, left_operand, right_operand) yields exactly one item
// on rsp (result_value, status). req.ready is high only while the sequencer is idle,
// so one item is worked on at a time.
// Path from accept to rsp.valid, with an empty output register:
//   compare, add, sub, logic ops, shifts and error cases: S_EXEC, then S_DONE
//   mul: S_EXEC, S_MUL_WAIT (four passes through one 32x32 multiplier), S_DONE
//   div, mod: S_EXEC, S_DIV_WAIT (restoring divider, one quotient bit per cycle), S_DONE
//   pow: one squaring, plus a multiply for each set bit, per exponent bit up to its
//   highest set bit; every product goes through the same multiplier
// The result sits in an output register; the next item is accepted while it waits.
// If rsp.ready stays low, a finished result holds in the sequencer until the output
// register frees up, and req.ready stays low meanwhile. Nothing is dropped.
// Reset (synchronous, active high) returns the sequencer to idle and empties the
// output register; no other state survives between items.
`include "int64_alu_with_power_top_macros.svh"

module int64_alu_with_power_top (
   input logic         clock,
   input logic         reset,
   i64alu_req_if.sink  req,
   i64alu_rsp_if.source rsp
);
   import i64alu_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EXEC     = 4'd1;
   localparam logic [3:0] S_MUL_WAIT = 4'd2;
   localparam logic [3:0] S_DIV_WAIT = 4'd3;
   localparam logic [3:0] S_POW_TEST = 4'd4;
   localparam logic [3:0] S_POW_ACC  = 4'd5;
   localparam logic [3:0] S_POW_SQ   = 4'd6;
   localparam logic [3:0] S_DONE     = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [4:0] func_ff, func_in;
   word_type   a_ff, a_in, b_ff, b_in;
   word_type   res_ff, res_in;
   logic [1:0] st_ff, st_in;
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_value_ff, rsp_value_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   mul_req_type mul_req;
   div_req_type div_req;
   logic        mul_done, div_done;
   word_type    mul_product, div_quotient, div_remainder;

   word_type   sum, diff, abs_a, abs_b, shr_arith, shr_logic, shl;
   logic       is_eq, is_lt, shift_ok;
   logic [5:0] sh;

   i64alu_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .done    (mul_done),
      .product (mul_product)
   );

   i64alu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign sum       = a_ff + b_ff;
   assign diff      = a_ff - b_ff;
   assign is_eq     = (a_ff == b_ff);
   assign is_lt     = ($signed(a_ff) < $signed(b_ff));
   assign sh        = b_ff[5:0];
   assign shift_ok  = (b_ff[WORD_W-1:6] == '0);
   assign shr_arith = word_type'($signed(a_ff) >>> sh);
   assign shr_logic = a_ff >> sh;
   assign shl       = a_ff << sh;
   assign abs_a     = a_ff[WORD_W-1] ? (~a_ff + word_type'(1)) : a_ff;
   assign abs_b     = b_ff[WORD_W-1] ? (~b_ff + word_type'(1)) : b_ff;

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      res_in        = res_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mul_req       = '{start: 1'b0, op_a: a_ff, op_b: b_ff};
      div_req       = '{start: 1'b0, dividend: abs_a, divisor: abs_b};

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               func_in  = req.func;
               a_in     = req.left_operand;
               b_in     = req.right_operand;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in   = '0;
            st_in    = ST_OK;
            state_in = S_DONE;
            case (func_ff)
               FN_EQ:  res_in = word_type'(is_eq);
               FN_NE:  res_in = word_type'(!is_eq);
               FN_LE:  res_in = word_type'(is_lt || is_eq);
               FN_GE:  res_in = word_type'(!is_lt);
               FN_LT:  res_in = word_type'(is_lt);
               FN_GT:  res_in = word_type'(!is_lt && !is_eq);
               FN_ADD: res_in = sum;
               FN_SUB: res_in = diff;
               FN_AND: res_in = a_ff & b_ff;
               FN_OR:  res_in = a_ff | b_ff;
               FN_XOR: res_in = a_ff ^ b_ff;
               FN_MUL: begin
                  mul_req.start = 1'b1;
                  state_in      = S_MUL_WAIT;
               end
               FN_DIV, FN_MOD: begin
                  if (b_ff == '0) begin
                     st_in = ST_DIV_ZERO;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = S_DIV_WAIT;
                  end
               end
               FN_ASR: begin
                  if (shift_ok) res_in = shr_arith;
                  else st_in = ST_SHIFT_RANGE;
               end
               FN_LSR: begin
                  if (shift_ok) res_in = shr_logic;
                  else st_in = ST_SHIFT_RANGE;
               end
               FN_SHL: begin
                  if (shift_ok) res_in = shl;
                  else st_in = ST_SHIFT_RANGE;
               end
               FN_POW: begin
                  // negative exponent gives zero
                  if (!b_ff[WORD_W-1]) begin
                     res_in   = word_type'(1);
                     state_in = S_POW_TEST;
                  end
               end
               default: ;
            endcase
         end
         S_MUL_WAIT: begin
            if (mul_done) begin
               res_in   = mul_product;
               state_in = S_DONE;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               // quotient truncates toward zero, remainder follows the dividend sign
               if (func_ff == FN_DIV) begin
                  res_in = (a_ff[WORD_W-1] ^ b_ff[WORD_W-1]) ?
                           (~div_quotient + word_type'(1)) : div_quotient;
               end else begin
                  res_in = a_ff[WORD_W-1] ? (~div_remainder + word_type'(1)) : div_remainder;
               end
               state_in = S_DONE;
            end
         end
         S_POW_TEST: begin
            // a_ff is the running base, b_ff the remaining exponent, res_ff the product
            if (b_ff == '0) begin
               state_in = S_DONE;
            end else if (b_ff[0]) begin
               mul_req       = '{start: 1'b1, op_a: res_ff, op_b: a_ff};
               state_in      = S_POW_ACC;
            end else begin
               mul_req       = '{start: 1'b1, op_a: a_ff, op_b: a_ff};
               state_in      = S_POW_SQ;
            end
         end
         S_POW_ACC: begin
            if (mul_done) begin
               res_in   = mul_product;
               mul_req  = '{start: 1'b1, op_a: a_ff, op_b: a_ff};
               state_in = S_POW_SQ;
            end
         end
         S_POW_SQ: begin
            if (mul_done) begin
               a_in     = mul_product;
               b_in     = b_ff >> 1;
               state_in = S_POW_TEST;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_ff;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      res_ff        <= res_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.status       = rsp_status_ff;

   `I64ALU_ASSERT_NEXT(a_accept_starts_exec, clock, reset, req.valid && req.ready, state_ff == S_EXEC, "accepted item did not start execution")
   `I64ALU_ASSERT_NOW(a_mul_done_expected, clock, reset, mul_done, state_ff == S_MUL_WAIT || state_ff == S_POW_ACC || state_ff == S_POW_SQ, "multiplier finished while nobody waited")
   `I64ALU_ASSERT_NOW(a_error_gives_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_value_ff == '0, "error status with nonzero result")

endmodule

[tb/sv/int64_alu_with_power_top_test.sv]
// self-checking testbench for the 64-bit integer alu with power
// depends on i64alu_pkg, i64alu_req_if, i64alu_rsp_if and int64_alu_with_power_top
`timescale 1ns / 1ps

module int64_alu_with_power_top_test;
   import i64alu_pkg::*;

   typedef struct packed {
      word_type   value;
      logic [1:0] status;
   } alu_result_type;

   localparam word_type MIN_WORD = {1'b1, {63{1'b0}}};
   localparam word_type MAX_WORD = {1'b0, {63{1'b1}}};
   localparam word_type ONE_WORD = word_type'(1);
   localparam logic [4:0] FN_TOP = 5'h1f;
   localparam int unsigned MAX_REPORTS = 10;

   logic clock;
   logic reset;

   i64alu_req_if req_ch ();
   i64alu_rsp_if rsp_ch ();

   int64_alu_with_power_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   alu_result_type pending_results[$];
   alu_result_type head_result;
   int unsigned    fail_count;
   int unsigned    send_idle_pct;
   int unsigned    rsp_stall_pct;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bit-exact prediction of one alu operation
   function automatic alu_result_type alu_predict(logic [4:0] fn, word_type a, word_type b);
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      word_type           acc;
      word_type           base;
      word_type           ex;
      alu_result_type     res;
      logic               shift_ok;
      sa = a;
      sb = b;
      res.value = '0;
      res.status = ST_OK;
      shift_ok = (b[63:6] == '0);
      case (fn)
         FN_EQ: res.value = word_type'(sa == sb);
         FN_NE: res.value = word_type'(sa != sb);
         FN_LE: res.value = word_type'(sa <= sb);
         FN_GE: res.value = word_type'(sa >= sb);
         FN_LT: res.value = word_type'(sa < sb);
         FN_GT: res.value = word_type'(sa > sb);
         FN_ADD: res.value = a + b;
         FN_SUB: res.value = a - b;
         FN_AND: res.value = a & b;
         FN_OR: res.value = a | b;
         FN_XOR: res.value = a ^ b;
         FN_MUL: res.value = a * b;
         FN_DIV, FN_MOD: begin
            if (b == '0) begin
               res.status = ST_DIV_ZERO;
            end else if (a == MIN_WORD && b == '1) begin
               res.value = (fn == FN_DIV) ? MIN_WORD : '0;
            end else if (fn == FN_DIV) begin
               res.value = sa / sb;
            end else begin
               res.value = sa % sb;
            end
         end
         FN_ASR, FN_LSR, FN_SHL: begin
            if (!shift_ok) begin
               res.status = ST_SHIFT_RANGE;
            end else if (fn == FN_ASR) begin
               res.value = sa >>> b[5:0];
            end else if (fn == FN_LSR) begin
               res.value = a >> b[5:0];
            end else begin
               res.value = a << b[5:0];
            end
         end
         FN_POW: begin
            // square and multiply, negative exponent gives zero
            acc = ONE_WORD;
            base = a;
            ex = b;
            if (ex[63]) begin
               acc = '0;
               ex = '0;
            end
            while (ex != '0) begin
               if (ex[0]) begin
                  acc = acc * base;
               end
               base = base * base;
               ex = ex >> 1;
            end
            res.value = acc;
         end
         default: res.value = '0;
      endcase
      return res;
   endfunction

   task automatic note_failure(string msg);
      if (fail_count < MAX_REPORTS) begin
         $display("%0t: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   // check results against the oldest prediction, then log newly accepted items
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               note_failure($sformatf("unexpected result value=%h status=%0d",
                                      rsp_ch.result_value, rsp_ch.status));
            end else begin
               head_result = pending_results.pop_front();
               if (rsp_ch.result_value !== head_result.value) begin
                  note_failure($sformatf("result_value mismatch: expected %h actual %h",
                                         head_result.value, rsp_ch.result_value));
               end
               if (rsp_ch.status !== head_result.status) begin
                  note_failure($sformatf("status mismatch: expected %0d actual %0d",
                                         head_result.status, rsp_ch.status));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_results.push_back(alu_predict(req_ch.func, req_ch.left_operand,
                                                  req_ch.right_operand));
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(logic [4:0] fn, word_type a, word_type b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= fn;
      req_ch.left_operand <= a;
      req_ch.right_operand <= b;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic word_type rand_operand();
      word_type v;
      case ($urandom_range(3))
         0: v = {$urandom, $urandom};
         1: v = word_type'($urandom_range(16)) - word_type'(8);
         2: begin
            case ($urandom_range(4))
               0: v = MIN_WORD;
               1: v = MAX_WORD;
               2: v = '0;
               3: v = '1;
               default: v = ONE_WORD;
            endcase
         end
         default: begin
            // mid-sized magnitudes of either sign
            v = {$urandom, $urandom} >> $urandom_range(63);
            if ($urandom_range(1)) begin
               v = -v;
            end
         end
      endcase
      return v;
   endfunction

   function automatic word_type rand_right(logic [4:0] fn, word_type a);
      word_type v;
      int unsigned pick;
      pick = $urandom_range(99);
      v = rand_operand();
      case (fn)
         FN_EQ, FN_NE, FN_LE, FN_GE, FN_LT, FN_GT: begin
            if (pick < 25) begin
               v = a;
            end else if (pick < 35) begin
               v = a + word_type'(pick[0] ? 1 : -1);
            end
         end
         FN_DIV, FN_MOD: begin
            if (pick < 10) begin
               v = '0;
            end else if (pick < 16) begin
               v = '1;
            end
         end
         FN_ASR, FN_LSR, FN_SHL: begin
            if (pick < 85) begin
               v = word_type'($urandom_range(63));
            end else if (pick < 92) begin
               v = word_type'(64 + $urandom_range(8));
            end
         end
         FN_POW: begin
            if (pick < 75) begin
               v = word_type'($urandom_range(20));
            end else if (pick < 85) begin
               v[63] = 1'b1;
            end else if (pick < 95) begin
               v = word_type'($urandom_range(63));
            end else begin
               v[63] = 1'b0;
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_directed_cases();
      send_item(FN_EQ, MAX_WORD, MAX_WORD);
      send_item(FN_NE, MIN_WORD, MAX_WORD);
      send_item(FN_LE, MIN_WORD, MAX_WORD);
      send_item(FN_GE, '1, '0);
      send_item(FN_LT, MAX_WORD, MIN_WORD);
      send_item(FN_GT, '0, '1);
      send_item(FN_ADD, MAX_WORD, ONE_WORD);
      send_item(FN_SUB, MIN_WORD, ONE_WORD);
      send_item(FN_AND, '1, 64'ha5a5_5a5a_f0f0_0f0f);
      send_item(FN_OR, 64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef);
      send_item(FN_XOR, '1, 64'h5555_aaaa_3333_cccc);
      send_item(FN_MUL, MIN_WORD, '1);
      send_item(FN_MUL, MAX_WORD, MAX_WORD);
      send_item(FN_DIV, MAX_WORD, '0);
      send_item(FN_MOD, MIN_WORD, '0);
      // most negative over minus one wraps
      send_item(FN_DIV, MIN_WORD, '1);
      send_item(FN_MOD, MIN_WORD, '1);
      // truncation toward zero, remainder takes the dividend sign
      send_item(FN_DIV, -word_type'(7), word_type'(2));
      send_item(FN_MOD, -word_type'(7), word_type'(2));
      send_item(FN_ASR, MIN_WORD, word_type'(63));
      send_item(FN_LSR, MIN_WORD, word_type'(63));
      send_item(FN_SHL, ONE_WORD, word_type'(63));
      send_item(FN_ASR, '1, word_type'(64));
      send_item(FN_SHL, ONE_WORD, '1);
      send_item(FN_POW, '0, '0);
      send_item(FN_POW, word_type'(3), '1);
      send_item(FN_POW, word_type'(3), MAX_WORD);
      send_item(FN_POW + 5'd1, '1, '1);
      send_item(FN_TOP, MAX_WORD, MIN_WORD);
   endtask

   task automatic test_random_items(int unsigned count);
      logic [4:0] fn;
      word_type   a;
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(99) < 92) begin
            fn = 5'($urandom_range(FN_POW));
         end else begin
            fn = 5'($urandom_range(FN_TOP, FN_POW + 5'd1));
         end
         a = rand_operand();
         send_item(fn, a, rand_right(fn, a));
      end
   endtask

   // sender holds off until the block has returned everything
   task automatic test_drain_pause();
      test_random_items(10);
      wait_for_results();
      @(negedge clock);
      test_random_items(10);
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = FN_EQ;
      req_ch.left_operand = '0;
      req_ch.right_operand = '0;
      rsp_ch.ready = 1'b0;
      fail_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_random_items(210);

      send_idle_pct = 78;
      rsp_stall_pct = 0;
      test_random_items(210);
      test_drain_pause();

      send_idle_pct = 0;
      rsp_stall_pct = 78;
      test_random_items(210);

      send_idle_pct = 6;
      rsp_stall_pct = 6;
      test_random_items(210);

      wait_for_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
